// ===== hw/rtl/txc_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none

package txc_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_BS    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Character codes and cell constants
  localparam logic [7:0]  CH_NEWLINE = 8'h0A;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [2:0]  TAB_STOP   = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PUT,
    ST_SCROLL,
    ST_SBLANK,
    ST_BS_SCAN,
    ST_BS_LAST,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/txc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer: screen buffer in RAM, cursor, and the command sequencer.
// Reads, newlines needing no scroll and in-row backspaces go straight to the result.
// A printable char is written after any pending wrap; a tab writes spaces to the
// next tab stop. Backspace to the previous row scans it. Clear writes one cell a
// cycle. A newline or wrap on the last row scrolls first. One item in flight: input
// reopens the cycle after the result loads, which waits while out_stall holds the
// output register. Synchronous reset; every cell is cleared before input opens.
`default_nettype none

module text_console_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_character,
  input  wire logic [7:0]  in_attribute,
  input  wire logic [10:0] in_cell_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data,
  output logic [4:0]       out_cur_row,
  output logic [6:0]       out_cursor_column
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLUMNS + 1);
  localparam int XW    = AW + 11;

  localparam logic [AW-1:0] COLS_A      = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] LAST_BASE   = AW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [AW-1:0] COPY_END    = AW'(CELLS - SCREEN_COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_START = AW'(CELLS - SCREEN_COLUMNS);
  localparam logic [AW-1:0] CELL_END    = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCAN_END    = AW'(SCREEN_COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] COLS_C      = CW'(SCREEN_COLUMNS);
  localparam logic [CW-1:0] LAST_COL    = CW'(SCREEN_COLUMNS - 1);
  localparam logic [XW-1:0] CELLS_X     = XW'(CELLS);

  // Control registers
  txc_pkg::state_t state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [2:0]    rem_r, rem_nxt;
  logic          ret_put_r, ret_put_nxt;
  logic          is_read_r, is_read_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [15:0]   out_data_r, out_data_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [6:0]    out_col_r, out_col_nxt;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [15:0]   rd_data;

  // Decode helpers
  logic          accept;
  logic          out_free;
  logic          is_tab;
  logic          rd_in_range;
  logic [XW-1:0] addr_x;
  logic [CW-1:0] bs_col;
  logic [15:0]   blank;

  assign accept      = in_valid && (state_r == txc_pkg::ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign is_tab      = (in_character == txc_pkg::CH_TAB);
  assign addr_x      = XW'(in_cell_address);
  assign rd_in_range = (addr_x < CELLS_X);
  assign bs_col      = (col_r == COLS_C) ? LAST_COL : (col_r - CW'(1));
  assign blank       = {attr_r, txc_pkg::CH_SPACE};

  txc_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      txc_pkg::ST_INIT: begin
        if (cnt_r == CELL_END) state_nxt = txc_pkg::ST_IDLE;
      end
      txc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            txc_pkg::FUNC_PUT: begin
              if (in_character == txc_pkg::CH_NEWLINE) begin
                state_nxt = (row_r == LAST_ROW) ? txc_pkg::ST_SCROLL : txc_pkg::ST_DONE;
              end else begin
                state_nxt = txc_pkg::ST_PUT;
              end
            end
            txc_pkg::FUNC_BS: begin
              if (col_r == '0 && row_r != '0) state_nxt = txc_pkg::ST_BS_SCAN;
              else state_nxt = txc_pkg::ST_DONE;
            end
            txc_pkg::FUNC_CLEAR: state_nxt = txc_pkg::ST_CLEAR;
            default: state_nxt = txc_pkg::ST_DONE;
          endcase
        end
      end
      txc_pkg::ST_CLEAR: begin
        if (cnt_r == CELL_END) state_nxt = txc_pkg::ST_DONE;
      end
      txc_pkg::ST_PUT: begin
        if (col_r == COLS_C) begin
          if (row_r == LAST_ROW) state_nxt = txc_pkg::ST_SCROLL;
        end else if (rem_r == 3'd1) begin
          state_nxt = txc_pkg::ST_DONE;
        end
      end
      txc_pkg::ST_SCROLL: begin
        if (cnt_r == COPY_END) state_nxt = txc_pkg::ST_SBLANK;
      end
      txc_pkg::ST_SBLANK: begin
        if (!pend_r && cnt_r == CELL_END) begin
          state_nxt = ret_put_r ? txc_pkg::ST_PUT : txc_pkg::ST_DONE;
        end
      end
      txc_pkg::ST_BS_SCAN: begin
        if (cnt_r == SCAN_END) state_nxt = txc_pkg::ST_BS_LAST;
      end
      txc_pkg::ST_BS_LAST: state_nxt = txc_pkg::ST_DONE;
      txc_pkg::ST_DONE: begin
        if (out_free) state_nxt = txc_pkg::ST_IDLE;
      end
      default: state_nxt = txc_pkg::ST_INIT;
    endcase
  end

  // Datapath, RAM control and result register
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    attr_nxt      = attr_r;
    ch_nxt        = ch_r;
    rem_nxt       = rem_r;
    ret_put_nxt   = ret_put_r;
    is_read_nxt   = is_read_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = blank;
    re            = 1'b0;
    raddr         = cnt_r;

    case (state_r)
      // Power-up clearing pass
      txc_pkg::ST_INIT: begin
        we      = 1'b1;
        wdata   = txc_pkg::RESET_CELL;
        cnt_nxt = cnt_r + AW'(1);
      end

      // Take an item and do its first step
      txc_pkg::ST_IDLE: begin
        if (accept) begin
          attr_nxt    = in_attribute;
          is_read_nxt = 1'b0;
          cnt_nxt     = '0;
          case (in_func)
            txc_pkg::FUNC_PUT: begin
              if (in_character == txc_pkg::CH_NEWLINE) begin
                col_nxt     = '0;
                ret_put_nxt = 1'b0;
                if (row_r != LAST_ROW) begin
                  row_nxt  = row_r + RW'(1);
                  base_nxt = base_r + COLS_A;
                end
              end else begin
                ch_nxt      = is_tab ? txc_pkg::CH_SPACE : in_character;
                rem_nxt     = is_tab ? (txc_pkg::TAB_STOP - {1'b0, col_r[1:0]}) : 3'd1;
                ret_put_nxt = 1'b1;
              end
            end
            txc_pkg::FUNC_BS: begin
              if (col_r != '0) begin
                we      = 1'b1;
                waddr   = base_r + AW'(bs_col);
                wdata   = {in_attribute, txc_pkg::CH_SPACE};
                col_nxt = bs_col;
              end else if (row_r != '0) begin
                row_nxt  = row_r - RW'(1);
                base_nxt = base_r - COLS_A;
              end
            end
            txc_pkg::FUNC_CLEAR: begin
              row_nxt  = '0;
              col_nxt  = '0;
              base_nxt = '0;
            end
            default: begin
              is_read_nxt = 1'b1;
              rd_ok_nxt   = rd_in_range;
              re          = rd_in_range;
              raddr       = addr_x[AW-1:0];
            end
          endcase
        end
      end

      // Blank the whole screen
      txc_pkg::ST_CLEAR: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
      end

      // Printable and tab-space writes, with deferred wrap
      txc_pkg::ST_PUT: begin
        if (col_r == COLS_C) begin
          col_nxt = '0;
          if (row_r != LAST_ROW) begin
            row_nxt  = row_r + RW'(1);
            base_nxt = base_r + COLS_A;
          end
        end else begin
          we      = 1'b1;
          waddr   = base_r + AW'(col_r);
          wdata   = {attr_r, ch_r};
          col_nxt = col_r + CW'(1);
          rem_nxt = rem_r - 3'd1;
        end
      end

      // Scroll: read the cell a row below, write it back in the next cycle
      txc_pkg::ST_SCROLL: begin
        re            = 1'b1;
        raddr         = cnt_r + COLS_A;
        we            = pend_r;
        waddr         = pend_addr_r;
        wdata         = rd_data;
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        cnt_nxt       = (cnt_r == COPY_END) ? BLANK_START : (cnt_r + AW'(1));
      end

      // Finish the last copy, then blank the bottom row
      txc_pkg::ST_SBLANK: begin
        we = 1'b1;
        if (pend_r) begin
          waddr = pend_addr_r;
          wdata = rd_data;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
          if (cnt_r == CELL_END) begin
            row_nxt  = LAST_ROW;
            col_nxt  = '0;
            base_nxt = LAST_BASE;
          end
        end
      end

      // Backspace into the previous row: find the end of its text
      txc_pkg::ST_BS_SCAN: begin
        re            = 1'b1;
        raddr         = base_r + cnt_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        cnt_nxt       = cnt_r + AW'(1);
        if (pend_r && rd_data[7:0] != txc_pkg::CH_SPACE) begin
          col_nxt = CW'(pend_addr_r) + CW'(1);
        end
      end
      txc_pkg::ST_BS_LAST: begin
        if (pend_r && rd_data[7:0] != txc_pkg::CH_SPACE) begin
          col_nxt = CW'(pend_addr_r) + CW'(1);
        end
      end

      // Load the result once the output slot is free
      txc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (is_read_r && rd_ok_r) ? rd_data : 16'h0000;
          out_row_nxt   = 5'(row_r);
          out_col_nxt   = 7'(col_r);
        end
      end

      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= txc_pkg::ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    attr_r      <= attr_nxt;
    ch_r        <= ch_nxt;
    rem_r       <= rem_nxt;
    ret_put_r   <= ret_put_nxt;
    is_read_r   <= is_read_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_data_r  <= out_data_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign in_stall          = (state_r != txc_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_cur_row       = out_row_r;
  assign out_cursor_column = out_col_r;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the text console writer: directed and random transfers.
`timescale 1ns / 100ps

module tb;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;
  // Worst case is a scroll on every item plus stalls, taken several times over
  localparam int LIMIT = 10_000_000;

  typedef struct packed {
    logic [15:0] read_data;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = txc_pkg::FUNC_READ;
  logic [7:0]  in_character = 8'h00;
  logic [7:0]  in_attribute = 8'h00;
  logic [10:0] in_cell_address = 11'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_read_data;
  logic [4:0]  out_cur_row;
  logic [6:0]  out_cursor_column;

  // Screen and cursor as the block should hold them
  logic [15:0]   screen_q [0:CELLS-1];
  int unsigned   cur_row;
  int unsigned   cur_col;
  console_view_t expected_views [$];
  console_view_t view_want;

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  text_console_writer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_character     (in_character),
    .in_attribute     (in_attribute),
    .in_cell_address  (in_cell_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_cur_row      (out_cur_row),
    .out_cursor_column(out_cursor_column)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] blank_cell(logic [7:0] attr);
    return {attr, txc_pkg::CH_SPACE};
  endfunction

  // Rows move up one, bottom row blanked with the item's attribute
  function automatic void scroll_screen(logic [7:0] attr);
    int i;
    for (i = 0; i < CELLS - COLS; i++) screen_q[i] = screen_q[i + COLS];
    for (i = CELLS - COLS; i < CELLS; i++) screen_q[i] = blank_cell(attr);
    cur_row = ROWS - 1;
  endfunction

  function automatic void advance_line(logic [7:0] attr);
    cur_row = cur_row + 1;
    cur_col = 0;
    if (cur_row >= ROWS) scroll_screen(attr);
  endfunction

  // Deferred wrap: a pending wrap resolves only when the next glyph lands
  function automatic void place_glyph(logic [7:0] ch, logic [7:0] attr);
    int unsigned idx;
    if (cur_col >= COLS) advance_line(attr);
    if (cur_row >= ROWS) scroll_screen(attr);
    idx = cur_row * COLS + cur_col;
    if (idx < CELLS) screen_q[idx] = {attr, ch};
    cur_col = cur_col + 1;
  endfunction

  function automatic void erase_back(logic [7:0] attr);
    int unsigned base;
    if (cur_col > 0) begin
      cur_col = cur_col - 1;
      if (cur_col >= COLS) cur_col = COLS - 1;
      screen_q[cur_row * COLS + cur_col] = blank_cell(attr);
    end else if (cur_row > 0) begin
      // step back to just past the last non-space glyph of the row above
      cur_row = cur_row - 1;
      base = cur_row * COLS;
      cur_col = COLS - 1;
      while (cur_col > 0 && screen_q[base + cur_col][7:0] == txc_pkg::CH_SPACE)
        cur_col = cur_col - 1;
      if (screen_q[base + cur_col][7:0] != txc_pkg::CH_SPACE) cur_col = cur_col + 1;
    end
  endfunction

  function automatic console_view_t console_apply(logic [1:0] func, logic [7:0] ch,
                                                  logic [7:0] attr, logic [10:0] addr);
    console_view_t view;
    int unsigned   spaces;
    int            i;
    view.read_data = 16'h0000;
    case (func)
      txc_pkg::FUNC_PUT: begin
        if (ch == txc_pkg::CH_NEWLINE) begin
          advance_line(attr);
        end else if (ch == txc_pkg::CH_TAB) begin
          spaces = txc_pkg::TAB_STOP - (cur_col % txc_pkg::TAB_STOP);
          repeat (spaces) place_glyph(txc_pkg::CH_SPACE, attr);
        end else begin
          place_glyph(ch, attr);
        end
      end
      txc_pkg::FUNC_BS: begin
        erase_back(attr);
      end
      txc_pkg::FUNC_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_q[i] = blank_cell(attr);
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (addr < CELLS) view.read_data = screen_q[addr];
      end
    endcase
    view.row = cur_row[4:0];
    view.col = cur_col[6:0];
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void flag_error(string what, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= 10)
      $display("error at cycle %0d: %s expected 0x%0h, got 0x%0h",
               cycle_count, what, want, got);
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        flag_error("unrequested result, read_data", 0, out_read_data);
      end else begin
        view_want = expected_views.pop_front();
        if (out_read_data !== view_want.read_data)
          flag_error("read_data", view_want.read_data, out_read_data);
        if (out_cur_row !== view_want.row)
          flag_error("cursor row", view_want.row, out_cur_row);
        if (out_cursor_column !== view_want.col)
          flag_error("cursor_column", view_want.col, out_cursor_column);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // One transfer; valid stays high on return so back-to-back items need no toggle
  task automatic send_item(input logic [1:0] func, input logic [7:0] ch,
                           input logic [7:0] attr, input logic [10:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_character    <= ch;
    in_attribute    <= attr;
    in_cell_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_views.push_back(console_apply(func, ch, attr, addr));
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    send_item(txc_pkg::FUNC_READ, 8'h00, 8'h00, 11'd0);
    send_item(txc_pkg::FUNC_READ, 8'hFF, 8'hFF, 11'(CELLS - 1));
    send_item(txc_pkg::FUNC_READ, 8'h00, 8'h00, 11'h7FF);   // beyond the screen reads zero
    send_item(txc_pkg::FUNC_BS, 8'h00, 8'hFF, 11'd0);       // home position: no change
  endtask

  task automatic test_put_and_tab();
    send_item(txc_pkg::FUNC_PUT, 8'h00, 8'h00, 11'd0);
    send_item(txc_pkg::FUNC_PUT, 8'hFF, 8'hFF, 11'h7FF);
    send_item(txc_pkg::FUNC_PUT, txc_pkg::CH_TAB, 8'h34, 11'd0);
    send_item(txc_pkg::FUNC_PUT, txc_pkg::CH_NEWLINE, 8'h56, 11'd0);
    send_item(txc_pkg::FUNC_BS, 8'h41, 8'h81, 11'd0);       // back to end of text on row 0
    send_item(txc_pkg::FUNC_BS, 8'h41, 8'h81, 11'd0);       // in-row blank
    send_item(txc_pkg::FUNC_READ, 8'h00, 8'h00, 11'd1);
  endtask

  task automatic test_wrap();
    send_item(txc_pkg::FUNC_CLEAR, 8'h00, 8'h5A, 11'd0);
    repeat (COLS / txc_pkg::TAB_STOP)
      send_item(txc_pkg::FUNC_PUT, txc_pkg::CH_TAB, 8'($urandom_range(0, 255)), 11'd0);
    send_item(txc_pkg::FUNC_READ, 8'h00, 8'h00, 11'(COLS - 1));
    send_item(txc_pkg::FUNC_BS, 8'h00, 8'hC3, 11'd0);       // wrap pending: blanks last cell
    send_item(txc_pkg::FUNC_PUT, 8'h5A, 8'h1E, 11'd0);      // fills last cell, wrap pending
    send_item(txc_pkg::FUNC_PUT, 8'h59, 8'h2F, 11'd0);      // wraps, then writes
    send_item(txc_pkg::FUNC_BS, 8'h00, 8'h11, 11'd0);
    send_item(txc_pkg::FUNC_BS, 8'h00, 8'h11, 11'd0);       // back onto row 0 past its glyph
    send_item(txc_pkg::FUNC_PUT, txc_pkg::CH_TAB, 8'h70, 11'd0); // tab from the full width
    send_item(txc_pkg::FUNC_READ, 8'h00, 8'h00, 11'(COLS));
  endtask

  // Sessions of text, newline-heavy scrolling and long wrapped lines, with noise
  task automatic test_random(input int goal);
    int          sent;
    int          kind;
    int          roll;
    int          put_end;
    int          nl_end;
    int          tab_end;
    int          bs_end;
    logic [1:0]  func;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [10:0] addr;
    sent = 0;
    drain_results();
    while (sent < goal) begin
      kind = $urandom_range(0, 2);
      case (kind)
        0: begin
          put_end = 50; nl_end = 58; tab_end = 68; bs_end = 82;
        end
        1: begin
          put_end = 32; nl_end = 70; tab_end = 74; bs_end = 86;
        end
        default: begin
          put_end = 50; nl_end = 50; tab_end = 72; bs_end = 82;
        end
      endcase
      if ($urandom_range(0, 99) < ((kind == 1) ? 10 : 30)) begin
        send_item(txc_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        sent++;
      end
      repeat ($urandom_range(20, 70)) begin
        roll = $urandom_range(0, 99);
        attr = 8'($urandom_range(0, 255));
        addr = 11'($urandom_range(0, 2047));
        ch   = ($urandom_range(0, 4) == 0) ? txc_pkg::CH_SPACE : 8'($urandom_range(0, 255));
        func = txc_pkg::FUNC_PUT;
        if (roll < 6) begin
          func = 2'($urandom_range(0, 3));
        end else if (roll < put_end) begin
          func = txc_pkg::FUNC_PUT;
        end else if (roll < nl_end) begin
          ch = txc_pkg::CH_NEWLINE;
        end else if (roll < tab_end) begin
          ch = txc_pkg::CH_TAB;
        end else if (roll < bs_end) begin
          func = txc_pkg::FUNC_BS;
        end else begin
          // half the reads hit the cursor row where the fresh text is
          func = txc_pkg::FUNC_READ;
          roll = $urandom_range(0, 9);
          if (roll < 5) addr = 11'(cur_row * COLS + $urandom_range(0, COLS - 1));
          else if (roll < 9) addr = 11'($urandom_range(0, CELLS - 1));
          else addr = 11'($urandom_range(CELLS, 2047));
        end
        if (sent < goal) begin
          send_item(func, ch, attr, addr);
          sent++;
        end
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < CELLS; i++) screen_q[i] = txc_pkg::RESET_CELL;
    cur_row = 0;
    cur_col = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 69;
    test_reset_state();
    test_put_and_tab();
    test_wrap();
    test_random(260);

    send_idle_pct = 69;
    recv_idle_pct = 25;
    test_random(260);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(260);

    drain_results();
    repeat (2100) @(posedge clk);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
